### hw/rtl/i2p_pkg.sv
`timescale 1ns / 1ps

package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;

    // stack commands from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

    // verdict of the precedence unit
    typedef struct packed {
        logic is_op;      // arriving symbol is an operator or parenthesis
        logic is_close;   // arriving symbol is ')'
        logic top_paren;  // stacked top is '(' or ')'
        logic pop_top;    // stacked top goes before the arriving symbol
    } prec_res_t;

endpackage

### hw/rtl/i2p_in_if.sv
`timescale 1ns / 1ps

interface i2p_in_if;
    import i2p_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);

endinterface

### hw/rtl/i2p_out_if.sv
`timescale 1ns / 1ps

interface i2p_out_if;
    import i2p_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             has_symbol;
    logic             end_of_expression;
    logic             overflow;

    modport source (
        output valid, output out_symbol, output has_symbol,
        output end_of_expression, output overflow, input ready
    );
    modport sink (
        input valid, input out_symbol, input has_symbol,
        input end_of_expression, input overflow, output ready
    );

endinterface

### hw/rtl/i2p_prec_unit.sv
`timescale 1ns / 1ps

module i2p_prec_unit
    import i2p_pkg::*;
(
    input  logic [SYM_W-1:0] top,
    input  logic [SYM_W-1:0] sym,
    output prec_res_t        res
);

    logic [2:0] rank_top;
    logic [2:0] rank_sym;

    // rank of the stacked character; a stacked ')' outranks everything
    always_comb
    begin
        case (top) inside
            CH_CARET:          rank_top = 3'd3;
            CH_STAR, CH_SLASH: rank_top = 3'd2;
            CH_PLUS, CH_MINUS: rank_top = 3'd1;
            CH_CLOSE:          rank_top = 3'd4;
            default:           rank_top = 3'd0;
        endcase
    end

    // rank of the arriving character; '(' outranks everything
    always_comb
    begin
        case (sym) inside
            CH_CARET:          rank_sym = 3'd3;
            CH_STAR, CH_SLASH: rank_sym = 3'd2;
            CH_PLUS, CH_MINUS: rank_sym = 3'd1;
            CH_OPEN:           rank_sym = 3'd4;
            default:           rank_sym = 3'd0;
        endcase
    end

    always_comb
    begin
        res.is_op     = (sym == CH_CARET) || (sym == CH_STAR) || (sym == CH_SLASH) ||
                        (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_OPEN) ||
                        (sym == CH_CLOSE);
        res.is_close  = (sym == CH_CLOSE);
        res.top_paren = (top == CH_OPEN) || (top == CH_CLOSE);
        // '(' against ')' in either order never pops
        if (((rank_top == 3'd4) && (rank_sym == 3'd4)) ||
            ((rank_top == 3'd0) && (rank_sym == 3'd0)))
        begin
            res.pop_top = 1'b0;
        end
        else
        begin
            res.pop_top = (rank_top >= rank_sym);
        end
    end

endmodule

### hw/rtl/i2p_stack.sv
`timescale 1ns / 1ps

module i2p_stack
    import i2p_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stk_cmd_t         cmd,
    input  logic [SYM_W-1:0] push_data,
    output logic [CNT_W-1:0] count,
    output logic [SYM_W-1:0] top,
    output logic             full
);

    logic [SYM_W-1:0] mem [STACK_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SYM_W-1:0] top_reg;
    logic [CNT_W-1:0] rd_ptr;
    logic             do_push;

    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign do_push = cmd.push && !full;

    // read address tracks the top as it will stand after this cycle
    assign rd_ptr = cmd.pop ? (count_reg - CNT_W'(2)) : (count_reg - CNT_W'(1));

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // pushed symbol bypasses the array so the top is right on the next cycle
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[count_reg[PTR_W-1:0]] <= push_data;
            top_reg                   <= push_data;
        end
        else
        begin
            top_reg <= mem[rd_ptr[PTR_W-1:0]];
        end
    end

    assign count = count_reg;
    assign top   = top_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop from empty stack");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in one cycle");
`endif

endmodule

### hw/rtl/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. One ASCII character per transaction
// on chars; postfix characters and a closing end marker leave on postfix. The
// block takes a character only when its sequencer is idle. The sequencer
// registers an accepted character in its idle state and then works on it in
// execute steps; every stacked symbol popped (mid-expression or in the final
// flush) takes a step of its own, the stack array having one read port whose
// registered output is the only view of the top. The end marker takes a
// further step of the flush. A stalled postfix sink holds the sequencer in
// whichever step wants to emit. Overflow reports a dropped push in the current
// expression and clears with the end marker.
module infix_to_postfix_converter_top
    import i2p_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    i2p_in_if.sink    chars,
    i2p_out_if.source postfix
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic             last_reg;
    logic             last_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic             ovalid_reg;
    logic             ovalid_next;
    logic [SYM_W-1:0] osym_reg;
    logic [SYM_W-1:0] osym_next;
    logic             ohas_reg;
    logic             ohas_next;
    logic             oend_reg;
    logic             oend_next;
    logic             oovf_reg;
    logic             oovf_next;

    logic             emit;
    logic [SYM_W-1:0] emit_sym;
    logic             emit_end;
    logic             out_free;

    stk_cmd_t         cmd;
    logic [CNT_W-1:0] stk_count;
    logic [SYM_W-1:0] stk_top;
    logic             stk_full;
    logic             stk_empty;
    prec_res_t        prec;

    i2p_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push_data (sym_reg),
        .count     (stk_count),
        .top       (stk_top),
        .full      (stk_full)
    );

    i2p_prec_unit u_prec (
        .top (stk_top),
        .sym (sym_reg),
        .res (prec)
    );

    assign stk_empty = (stk_count == '0);
    assign out_free  = !ovalid_reg || postfix.ready;

    always_comb
    begin
        state_next = state_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        emit       = 1'b0;
        emit_sym   = stk_top;
        emit_end   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (chars.valid)
                begin
                    sym_next   = chars.symbol;
                    last_next  = chars.last;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (!prec.is_op)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_sym   = sym_reg;
                        state_next = last_reg ? ST_FLUSH : ST_IDLE;
                    end
                end
                else if (!stk_empty && prec.pop_top)
                begin
                    // parentheses leave the stack silently
                    if (prec.top_paren)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        cmd.pop = 1'b1;
                        emit    = 1'b1;
                    end
                end
                else
                begin
                    if (stk_empty || !prec.is_close)
                    begin
                        cmd.push = 1'b1;
                        if (stk_full)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // drop the matching open parenthesis
                        cmd.pop = 1'b1;
                    end
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (!stk_empty)
                begin
                    if (prec.top_paren)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        cmd.pop = 1'b1;
                        emit    = 1'b1;
                    end
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_sym   = '0;
                    emit_end   = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg && !postfix.ready;
        osym_next   = osym_reg;
        ohas_next   = ohas_reg;
        oend_next   = oend_reg;
        oovf_next   = oovf_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            osym_next   = emit_sym;
            ohas_next   = !emit_end;
            oend_next   = emit_end;
            oovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        osym_reg <= osym_next;
        ohas_reg <= ohas_next;
        oend_reg <= oend_next;
        oovf_reg <= oovf_next;
    end

    assign chars.ready               = (state_reg == ST_IDLE);
    assign postfix.valid             = ovalid_reg;
    assign postfix.out_symbol        = osym_reg;
    assign postfix.has_symbol        = ohas_reg;
    assign postfix.end_of_expression = oend_reg;
    assign postfix.overflow          = oovf_reg;

`ifndef ASSERT_OFF
    a_marker_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oend_reg) |-> (!ohas_reg && (osym_reg == '0)))
        else $error("end marker carries a character");

    a_marker_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_end) |=> (!ovf_reg && (state_reg == ST_IDLE)))
        else $error("overflow not cleared after end marker");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !postfix.ready) |=>
            (ovalid_reg && $stable(osym_reg) && $stable(ohas_reg) &&
             $stable(oend_reg) && $stable(oovf_reg)))
        else $error("postfix transaction changed while stalled");
`endif

endmodule
